>>> sv/trapezoid_ramp_planner_assert.svh
// ----------------------------------------------------------------------------
// trapezoid ramp planner assertion macros
// concurrent checks, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_RAMP_PLANNER_ASSERT_SVH
`define TRAPEZOID_RAMP_PLANNER_ASSERT_SVH
`ifndef SYNTH
// property check with reset disable
`define TRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// signal low in the cycle after reset
`define TRP_IDLE_AFTER_RESET(lbl, clk, rst_n, sig, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> !sig) else $error(msg);
`else
`define TRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRP_IDLE_AFTER_RESET(lbl, clk, rst_n, sig, msg)
`endif
`endif

>>> sv/trp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg
// types, constants and per-stage arithmetic of the ramp planner pipeline
// ----------------------------------------------------------------------------
package trp_pkg;

  localparam logic [19:0] USEC          = 20'd1000000;
  localparam logic [39:0] VEL_MAX       = 40'h7F_FFFF_FFFF;
  localparam logic [31:0] DUR_MAX       = 32'hFFFF_FFFF;
  localparam logic [15:0] STEPS_REV_RST = 16'd200;
  localparam logic [9:0]  DEG_PER_REV   = 10'd360;
  localparam logic [7:0]  POWER_MAX     = 8'd8;
  // reciprocals of 45 for a 29 bit and a 22 bit numerator
  localparam logic [29:0] REV_RECIP_HI  = 30'd763549742;
  localparam logic [22:0] REV_RECIP_LO  = 23'd5965233;

  // stage map
  localparam int unsigned ST_MUL_X       = 0;
  localparam int unsigned ST_MUL_P       = 1;
  localparam int unsigned ST_SUM_P       = 2;
  localparam int unsigned ST_DIV_FIRST   = 3;
  localparam int unsigned DIV_BITS       = 64;
  localparam int unsigned SHORT_DIV_BITS = 32;
  localparam int unsigned ST_ROOT_INIT   = ST_DIV_FIRST + DIV_BITS;
  localparam int unsigned ROOT_STEPS     = 32;
  localparam int unsigned ST_ROOT_FIRST  = ST_ROOT_INIT + 1;
  localparam int unsigned ST_SCALE       = ST_ROOT_FIRST + ROOT_STEPS;
  localparam int unsigned ST_REV_REM     = ST_SCALE + 1;
  localparam int unsigned ST_REV_FRAC    = ST_SCALE + 2;
  localparam int unsigned ST_REV_DIV     = ST_SCALE + 3;
  localparam int unsigned ST_OUT         = ST_SCALE + 4;
  localparam int unsigned N_STEPS        = ST_OUT + 1;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_POWER = 2'd1,
    ERR_SPEED = 2'd2
  } err_e;

  typedef enum logic {
    KIND_RAMP  = 1'b0,
    KIND_COAST = 1'b1
  } kind_e;

  typedef struct packed {
    logic        neg;
    logic [3:0]  pw;
    err_e        err;
    logic [31:0] d;
    logic [31:0] v;
    logic [31:0] r;
    logic [50:0] x;
    logic [63:0] pa_lo;
    logic [50:0] pa_hi;
    logic [63:0] pb_lo;
    logic [50:0] pb_hi;
    logic [31:0] a_rem;
    logic [31:0] a_q;
    logic        a_sat;
    logic [31:0] b_rem;
    logic [63:0] b_q;
    logic [31:0] c_rem;
    logic [63:0] c_q;
    logic        c_sat;
    logic        trap;
    logic [33:0] sb_rem;
    logic [31:0] sb_root;
    logic [33:0] sc_rem;
    logic [31:0] sc_root;
    logic [31:0] rt;
    logic [31:0] coast;
    logic [31:0] deg;
    logic [23:0] rev_q;
    logic [8:0]  rev_r;
    logic [39:0] fq;
    logic [24:0] fr;
    logic [15:0] fr_q;
    logic [39:0] vel;
  } st_t;

  // one restoring division bit: {quotient bit, remainder}
  function automatic logic [32:0] div_bit(logic [31:0] rem, logic b, logic [31:0] dv);
    logic [32:0] tmp;
    logic [32:0] dif;
    tmp = {rem, b};
    dif = tmp - {1'b0, dv};
    if (tmp >= {1'b0, dv}) begin
      return {1'b1, dif[31:0]};
    end
    return {1'b0, tmp[31:0]};
  endfunction

  // one square root digit: {root bit, remainder}
  function automatic logic [34:0] sqrt_bit(logic [33:0] rem, logic [1:0] two,
                                           logic [31:0] root);
    logic [35:0] tmp;
    logic [35:0] trial;
    logic [35:0] dif;
    tmp   = {rem, two};
    trial = {2'b00, root, 2'b01};
    dif   = tmp - trial;
    if (tmp >= trial) begin
      return {1'b1, dif[33:0]};
    end
    return {1'b0, tmp[33:0]};
  endfunction

  function automatic st_t trp_step(int unsigned k, st_t s, logic [15:0] f);
    st_t         n;
    logic [51:0] xp;
    logic [82:0] n1;
    logic [82:0] n2;
    logic [32:0] ra;
    logic [32:0] rb;
    logic [32:0] rc;
    logic [34:0] qb;
    logic [34:0] qc;
    logic [31:0] deg;
    logic [58:0] pq;
    logic [32:0] mq;
    logic [31:0] rr;
    logic [44:0] pf;
    logic [40:0] tot;
    logic [39:0] mag;
    n = s;
    if (k == ST_MUL_X) begin
      xp  = s.d * USEC;
      n.x = xp[50:0];
    end else if (k == ST_MUL_P) begin
      n.pa_lo = s.x[31:0] * s.v;
      n.pa_hi = s.x[50:32] * s.v;
      n.pb_lo = s.x[31:0] * s.r;
      n.pb_hi = s.x[50:32] * s.r;
    end else if (k == ST_SUM_P) begin
      n1      = {s.pa_hi, 32'd0} + {19'd0, s.pa_lo};
      n2      = {s.pb_hi, 32'd0} + {19'd0, s.pb_lo};
      n.a_rem = {13'd0, s.x[50:32]};
      n.a_q   = s.x[31:0];
      n.a_sat = {13'd0, s.x[50:32]} >= s.v;
      n.b_rem = {13'd0, n1[82:64]};
      n.b_q   = n1[63:0];
      n.c_rem = {13'd0, n2[82:64]};
      n.c_q   = n2[63:0];
      n.c_sat = {13'd0, n2[82:64]} >= s.v;
    end else if (k < ST_ROOT_INIT) begin
      rb      = div_bit(s.b_rem, s.b_q[63], s.r);
      n.b_rem = rb[31:0];
      n.b_q   = {s.b_q[62:0], rb[32]};
      rc      = div_bit(s.c_rem, s.c_q[63], s.v);
      n.c_rem = rc[31:0];
      n.c_q   = {s.c_q[62:0], rc[32]};
      if (k < ST_DIV_FIRST + SHORT_DIV_BITS) begin
        ra      = div_bit(s.a_rem, s.a_q[31], s.v);
        n.a_rem = ra[31:0];
        n.a_q   = {s.a_q[30:0], ra[32]};
      end
    end else if (k == ST_ROOT_INIT) begin
      n.a_q     = s.a_sat ? DUR_MAX : s.a_q;
      n.trap    = s.r <= n.a_q;
      n.coast   = n.a_q - s.r;
      n.sb_rem  = '0;
      n.sb_root = '0;
      n.sc_rem  = '0;
      n.sc_root = '0;
    end else if (k < ST_SCALE) begin
      qb        = sqrt_bit(s.sb_rem, s.b_q[63:62], s.sb_root);
      n.sb_rem  = qb[33:0];
      n.sb_root = {s.sb_root[30:0], qb[34]};
      n.b_q     = {s.b_q[61:0], 2'b00};
      qc        = sqrt_bit(s.sc_rem, s.c_q[63:62], s.sc_root);
      n.sc_rem  = qc[33:0];
      n.sc_root = {s.sc_root[30:0], qc[34]};
      n.c_q     = {s.c_q[61:0], 2'b00};
    end else if (k == ST_SCALE) begin
      // whole turns in the speed
      deg     = s.trap ? s.v : s.sb_root;
      n.rt    = s.c_sat ? DUR_MAX : s.sc_root;
      n.deg   = deg;
      pq      = deg[31:3] * REV_RECIP_HI;
      n.rev_q = pq[58:35];
    end else if (k == ST_REV_REM) begin
      mq      = s.rev_q * DEG_PER_REV;
      rr      = s.deg - mq[31:0];
      n.rev_r = rr[8:0];
      n.fq    = f * s.rev_q;
    end else if (k == ST_REV_FRAC) begin
      n.fr = f * s.rev_r;
    end else if (k == ST_REV_DIV) begin
      pf     = s.fr[24:3] * REV_RECIP_LO;
      n.fr_q = pf[43:28];
    end else begin
      tot   = {1'b0, s.fq} + {25'd0, s.fr_q};
      mag   = (tot > {1'b0, VEL_MAX}) ? VEL_MAX : tot[39:0];
      n.vel = s.neg ? (40'd0 - mag) : mag;
    end
    return n;
  endfunction

endpackage

>>> sv/trp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp interfaces
// move request, segment result and turn size channels
// ----------------------------------------------------------------------------
interface trp_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_deg;
  logic [31:0] max_speed_deg;
  logic [31:0] ramp_time_us;
  logic [7:0]  ustep_pow;
  modport source (output valid, distance_deg, max_speed_deg, ramp_time_us,
                  ustep_pow, input ready);
  modport sink (input valid, distance_deg, max_speed_deg, ramp_time_us,
                ustep_pow, output ready);
endinterface

interface trp_res_if;
  logic        valid;
  logic        ready;
  logic        segment_kind;
  logic [3:0]  microstep_code;
  logic [39:0] vel_begin;
  logic [39:0] vel_end;
  logic [31:0] seg_time_us;
  logic        last;
  logic [1:0]  error_code;
  modport source (output valid, segment_kind, microstep_code, vel_begin,
                  vel_end, seg_time_us, last, error_code, input ready);
  modport sink (input valid, segment_kind, microstep_code, vel_begin,
                vel_end, seg_time_us, last, error_code, output ready);
endinterface

interface trp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] full_steps_per_rev;
  modport source (output valid, full_steps_per_rev, input ready);
  modport sink (input valid, full_steps_per_rev, output ready);
endinterface

>>> sv/trapezoid_ramp_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid ramp planner
// turns a relative move request into accelerate, coast and decelerate segments
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req_i    in   distance_deg, max_speed_deg, ramp_time_us, ustep_pow
//  res_o    out  segment_kind .. error_code, one request gives 1 to 3 results
//  cfg_i    in   full_steps_per_rev
//
// a request passes through the arithmetic pipeline (bit-serial dividers
// and roots, one bit per stage) and then waits in the result register
// a request can enter every cycle while the result register is empty or ready to
// pass on its last segment; that register sends one segment per cycle while res_o
// is ready, so its segment count sets the rate; when res_o stalls the whole pipeline
// holds; reset clears the valid bits and sets full_steps_per_rev to 200
`include "trapezoid_ramp_planner_assert.svh"

module trapezoid_ramp_planner (
  input  logic    clk_i,
  input  logic    rst_ni,
  trp_req_if.sink   req_i,
  trp_res_if.source res_o,
  trp_cfg_if.sink   cfg_i
);
  import trp_pkg::*;

  logic [15:0]  cfg_q;
  st_t          entry;
  st_t          pipe_q [N_STEPS+1];
  logic [N_STEPS:0] pv_q;
  st_t          hold_q;
  logic         hold_v_q;
  logic [1:0]   seg_q;
  logic         adv;
  logic         fin;
  logic [31:0]  span;

  // turn size register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= STEPS_REV_RST;
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.full_steps_per_rev;
    end
  end

  // request capture
  assign span = req_i.distance_deg;

  always_comb begin
    entry     = '0;
    entry.neg = span[31];
    entry.d   = span[31] ? (32'd0 - span) : span;
    entry.v   = req_i.max_speed_deg;
    entry.r   = req_i.ramp_time_us;
    entry.pw  = req_i.ustep_pow[3:0];
    if (req_i.max_speed_deg == 32'd0) begin
      entry.err = ERR_SPEED;
    end else if (req_i.ustep_pow > POWER_MAX) begin
      entry.err = ERR_POWER;
    end else begin
      entry.err = ERR_NONE;
    end
  end

  assign adv         = !hold_v_q || (res_o.ready && fin);
  assign req_i.ready = adv;

  // arithmetic pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (adv) begin
      pv_q <= {pv_q[N_STEPS-1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= entry;
      for (int unsigned k = 0; k < N_STEPS; k++) begin
        pipe_q[k+1] <= trp_step(k, pipe_q[k], cfg_q);
      end
    end
  end

  // result register and segment sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      seg_q    <= 2'd0;
    end else if (adv) begin
      hold_v_q <= pv_q[N_STEPS];
      seg_q    <= 2'd0;
    end else if (res_o.ready) begin
      seg_q <= seg_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hold_q <= pipe_q[N_STEPS];
    end
  end

  always_comb begin
    res_o.segment_kind   = KIND_RAMP;
    res_o.microstep_code = hold_q.pw;
    res_o.vel_begin      = '0;
    res_o.vel_end        = '0;
    res_o.seg_time_us    = '0;
    fin                  = 1'b0;
    res_o.error_code     = ERR_NONE;
    if (hold_q.err != ERR_NONE) begin
      res_o.microstep_code = '0;
      fin                  = 1'b1;
      res_o.error_code     = hold_q.err;
    end else if (hold_q.trap) begin
      case (seg_q)
        2'd0: begin
          res_o.vel_end     = hold_q.vel;
          res_o.seg_time_us = hold_q.r;
        end
        2'd1: begin
          res_o.segment_kind = KIND_COAST;
          res_o.vel_begin    = hold_q.vel;
          res_o.vel_end      = hold_q.vel;
          res_o.seg_time_us  = hold_q.coast;
        end
        default: begin
          res_o.vel_begin   = hold_q.vel;
          res_o.seg_time_us = hold_q.r;
          fin               = 1'b1;
        end
      endcase
    end else begin
      case (seg_q)
        2'd0: begin
          res_o.vel_end     = hold_q.vel;
          res_o.seg_time_us = hold_q.rt;
        end
        default: begin
          res_o.vel_begin   = hold_q.vel;
          res_o.seg_time_us = hold_q.rt;
          fin               = 1'b1;
        end
      endcase
    end
  end

  assign res_o.valid = hold_v_q;
  assign res_o.last  = fin;

  `TRP_ASSERT(a_seg_idle, clk_i, rst_ni, !hold_v_q |-> (seg_q == 2'd0), "segment count set")
  `TRP_ASSERT(a_err_single, clk_i, rst_ni, (hold_v_q && (hold_q.err != ERR_NONE)) |-> fin,
              "error result not final")
  `TRP_ASSERT(a_stall_hold, clk_i, rst_ni,
              (hold_v_q && !res_o.ready) |=> (hold_v_q && $stable(seg_q)), "stalled segment moved")
  `TRP_IDLE_AFTER_RESET(a_rst_idle, clk_i, rst_ni, res_o.valid, "result valid after reset")

endmodule
